// ===== src/efr_pkg.sv =====
// Shared constants and types for the escaped frame receiver.
package efr_pkg;

    localparam logic [7:0]  START_BYTE  = 8'h7E;
    localparam logic [7:0]  ESC_BYTE    = 8'h7D;
    localparam logic [7:0]  ESC_XOR     = 8'h20;
    localparam logic [7:0]  SUM_BASE    = 8'hFF;
    localparam logic [15:0] MAX_LEN_RST = 16'd100;

    typedef enum logic [1:0] {
        ST_DATA  = 2'd0,
        ST_GOOD  = 2'd1,
        ST_BAD   = 2'd2,
        ST_ABORT = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] byte_index;
        status_t     frame_status;
        logic        end_of_frame;
    } result_t;

endpackage

// ===== src/efr_deframer.sv =====
// Frame parsing state machine with the result register.
module efr_deframer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  logic [7:0]        item_byte,
    input  logic [15:0]       max_len,
    output logic              item_take,
    output logic              res_valid,
    input  logic              res_ready,
    output efr_pkg::result_t  res
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_CKSUM  = 3'd4
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              esc_reg, esc_next;
    logic [15:0]       len_reg, len_next;
    logic [15:0]       seen_reg, seen_next;
    logic [7:0]        sum_reg, sum_next;
    logic              res_valid_reg, res_valid_next;
    efr_pkg::result_t  res_reg, res_next;

    logic              emit;
    logic [7:0]        b;
    logic [15:0]       full_len;
    logic [15:0]       seen_inc;
    logic [7:0]        expect_sum;

    assign item_take  = item_valid && (!res_valid_reg || res_ready);
    assign b          = esc_reg ? (item_byte ^ efr_pkg::ESC_XOR) : item_byte;
    assign full_len   = {len_reg[15:8], b};
    assign seen_inc   = seen_reg + 16'd1;
    assign expect_sum = efr_pkg::SUM_BASE - sum_reg;

    always_comb
    begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        emit       = 1'b0;
        res_next   = res_reg;

        if (item_take)
        begin
            unique case (phase_reg)
                PH_LEN_HI, PH_LEN_LO, PH_DATA, PH_CKSUM:
                begin
                    if (item_byte == efr_pkg::START_BYTE)
                    begin
                        // A raw start inside a frame aborts it and opens a new one.
                        emit                  = 1'b1;
                        res_next.data_byte    = 8'd0;
                        res_next.byte_index   = seen_reg;
                        res_next.frame_status = efr_pkg::ST_ABORT;
                        res_next.end_of_frame = 1'b1;
                        phase_next = PH_LEN_HI;
                        esc_next   = 1'b0;
                        len_next   = 16'd0;
                        seen_next  = 16'd0;
                        sum_next   = 8'd0;
                    end
                    else if (!esc_reg && item_byte == efr_pkg::ESC_BYTE)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        esc_next = 1'b0;
                        unique case (phase_reg)
                            PH_LEN_HI:
                            begin
                                len_next   = {b, 8'd0};
                                phase_next = PH_LEN_LO;
                            end
                            PH_LEN_LO:
                            begin
                                len_next = full_len;
                                if (full_len > max_len)
                                begin
                                    emit                  = 1'b1;
                                    res_next.data_byte    = 8'd0;
                                    res_next.byte_index   = 16'd0;
                                    res_next.frame_status = efr_pkg::ST_ABORT;
                                    res_next.end_of_frame = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else if (full_len == 16'd0)
                                    phase_next = PH_CKSUM;
                                else
                                    phase_next = PH_DATA;
                            end
                            PH_DATA:
                            begin
                                emit                  = 1'b1;
                                res_next.data_byte    = b;
                                res_next.byte_index   = seen_reg;
                                res_next.frame_status = efr_pkg::ST_DATA;
                                res_next.end_of_frame = 1'b0;
                                sum_next  = sum_reg + b;
                                seen_next = seen_inc;
                                if (seen_inc == len_reg)
                                    phase_next = PH_CKSUM;
                            end
                            default:
                            begin
                                emit                  = 1'b1;
                                res_next.data_byte    = 8'd0;
                                res_next.byte_index   = seen_reg;
                                res_next.frame_status = (expect_sum == b) ?
                                                        efr_pkg::ST_GOOD :
                                                        efr_pkg::ST_BAD;
                                res_next.end_of_frame = 1'b1;
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    // Idle ignores everything but a raw start; escapes do not apply.
                    if (item_byte == efr_pkg::START_BYTE)
                    begin
                        phase_next = PH_LEN_HI;
                        esc_next   = 1'b0;
                        len_next   = 16'd0;
                        seen_next  = 16'd0;
                        sum_next   = 8'd0;
                    end
                    else
                        phase_next = PH_IDLE;
                end
            endcase
        end

        if (emit)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            esc_reg       <= 1'b0;
            len_reg       <= 16'd0;
            seen_reg      <= 16'd0;
            sum_reg       <= 8'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            esc_reg       <= esc_next;
            len_reg       <= len_next;
            seen_reg      <= seen_next;
            sum_reg       <= sum_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ===== src/escaped_frame_receiver_core.sv =====
// Top level of the escaped frame receiver: input register, limit register, deframer.
// Each byte passes through the input register into the deframer, whose result register holds its result.
// Throughput: one byte per cycle, unless a result held in the deframer stalls on out_ready.
// A byte that causes no result still occupies the input register until the deframer takes it.
// Reset (rst_n, asynchronous, active low) empties both registers, sets the phase to
// idle with length, count, sum and escape cleared, and loads max_frame_length = 100.
module escaped_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  data_byte,
    output logic [15:0] byte_index,
    output logic [1:0]  frame_status,
    output logic        end_of_frame
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic [15:0]       max_len_reg;
    logic              take;
    efr_pkg::result_t  res;

    assign in_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            max_len_reg  <= efr_pkg::MAX_LEN_RST;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (cfg_wr_en)
                max_len_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
    end

    efr_deframer u_deframer (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item_byte  (in_byte_reg),
        .max_len    (max_len_reg),
        .item_take  (take),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign data_byte    = res.data_byte;
    assign byte_index   = res.byte_index;
    assign frame_status = res.frame_status;
    assign end_of_frame = res.end_of_frame;

endmodule

// ===== tb/escaped_frame_receiver_core_tb.sv =====
// Self-checking testbench for the escaped frame receiver core.
`timescale 1ns / 1ps

module escaped_frame_receiver_core_tb ();

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BYTES  = 150;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 4;

    typedef enum logic [2:0] {
        RX_IDLE   = 3'd0,
        RX_LEN_HI = 3'd1,
        RX_LEN_LO = 3'd2,
        RX_DATA   = 3'd3,
        RX_CKSUM  = 3'd4
    } rx_phase_t;

    // Tracks the deframer state and holds the results it should produce, oldest first.
    class deframe_tracker;
        rx_phase_t         phase;
        bit                escape_pending;
        logic [15:0]       frame_len;
        logic [15:0]       seen_count;
        logic [7:0]        data_sum;
        logic [15:0]       limit;
        efr_pkg::result_t  awaited_results[$];
        int                errors;

        function new();
            limit  = efr_pkg::MAX_LEN_RST;
            errors = 0;
            restart();
            phase = RX_IDLE;
        endfunction

        function void restart();
            phase          = RX_LEN_HI;
            escape_pending = 1'b0;
            frame_len      = 16'd0;
            seen_count     = 16'd0;
            data_sum       = 8'd0;
        endfunction

        function void queue_result(logic [7:0] value, logic [15:0] idx,
                                   efr_pkg::status_t st);
            efr_pkg::result_t r;
            r.data_byte    = value;
            r.byte_index   = idx;
            r.frame_status = st;
            r.end_of_frame = (st != efr_pkg::ST_DATA);
            awaited_results.push_back(r);
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_rx_byte(logic [7:0] raw);
            logic [7:0]  value;
            logic [7:0]  good_sum;
            logic [15:0] cut_count;
            if (phase == RX_IDLE)
            begin
                if (raw == efr_pkg::START_BYTE)
                    restart();
                return;
            end
            // A raw start byte always wins, even over a pending escape.
            if (raw == efr_pkg::START_BYTE)
            begin
                cut_count = seen_count;
                restart();
                queue_result(8'd0, cut_count, efr_pkg::ST_ABORT);
                return;
            end
            if (!escape_pending && raw == efr_pkg::ESC_BYTE)
            begin
                escape_pending = 1'b1;
                return;
            end
            value          = escape_pending ? (raw ^ efr_pkg::ESC_XOR) : raw;
            escape_pending = 1'b0;
            case (phase)
                RX_LEN_HI:
                begin
                    frame_len = {value, 8'h00};
                    phase     = RX_LEN_LO;
                end
                RX_LEN_LO:
                begin
                    frame_len[7:0] = value;
                    if (frame_len > limit)
                    begin
                        phase = RX_IDLE;
                        queue_result(8'd0, 16'd0, efr_pkg::ST_ABORT);
                    end
                    else
                        phase = (frame_len == 16'd0) ? RX_CKSUM : RX_DATA;
                end
                RX_DATA:
                begin
                    queue_result(value, seen_count, efr_pkg::ST_DATA);
                    data_sum   = data_sum + value;
                    seen_count = seen_count + 16'd1;
                    if (seen_count == frame_len)
                        phase = RX_CKSUM;
                end
                default:
                begin
                    good_sum = efr_pkg::SUM_BASE - data_sum;
                    phase    = RX_IDLE;
                    queue_result(8'd0, seen_count,
                                 (good_sum == value) ? efr_pkg::ST_GOOD : efr_pkg::ST_BAD);
                end
            endcase
        endfunction

        function void check_frame_result(efr_pkg::result_t got);
            efr_pkg::result_t want;
            if (awaited_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result data=%h idx=%0d status=%0d eof=%b",
                             $realtime, got.data_byte, got.byte_index, got.frame_status,
                             got.end_of_frame);
                return;
            end
            want = awaited_results.pop_front();
            if (got.data_byte !== want.data_byte || got.byte_index !== want.byte_index ||
                got.frame_status !== want.frame_status ||
                got.end_of_frame !== want.end_of_frame)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: result wrong: expected data=%h idx=%0d status=%0d eof=%b,",
                              " got data=%h idx=%0d status=%0d eof=%b"},
                             $realtime, want.data_byte, want.byte_index, want.frame_status,
                             want.end_of_frame, got.data_byte, got.byte_index,
                             got.frame_status, got.end_of_frame);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [1:0]  frame_status;
    logic        end_of_frame;

    deframe_tracker board = new();
    logic [7:0]     line_bytes[$];
    bit             gaps_on = 1'b1;
    bit             hold_request = 1'b0;

    // Idle noise, an empty frame, escapes in data, an oversize length, and a start
    // byte arriving with an escape pending followed by a one-byte frame.
    logic [7:0] opening_bytes [0:28] = '{
        8'h00, 8'hFF, 8'h7D,
        8'h7E, 8'h00, 8'h00, 8'hFF,
        8'h7E, 8'h00, 8'h03, 8'h7D, 8'h5E, 8'h7D, 8'h7D, 8'hFF, 8'h00,
        8'h7E, 8'hFF, 8'hFF,
        8'h7E, 8'h00, 8'h05, 8'h41, 8'h7D, 8'h7E, 8'h00, 8'h01, 8'h00, 8'hFF
    };

    escaped_frame_receiver_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .byte_index   (byte_index),
        .frame_status (frame_status),
        .end_of_frame (end_of_frame)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void add_field(input logic [7:0] value);
        if (value == efr_pkg::START_BYTE || value == efr_pkg::ESC_BYTE ||
            $urandom_range(0, 9) == 0)
        begin
            line_bytes.push_back(efr_pkg::ESC_BYTE);
            line_bytes.push_back(value ^ efr_pkg::ESC_XOR);
        end
        else
            line_bytes.push_back(value);
    endfunction

    // Builds one frame, a broken frame, an oversize header or idle noise into line_bytes.
    task automatic add_frame(input logic [15:0] cap, inout int count);
        int          kind;
        int          top;
        int          cut;
        logic [15:0] len;
        logic [7:0]  sum;
        logic [7:0]  value;
        kind = $urandom_range(0, 19);
        top  = (cap < 12) ? cap : 12;
        if (kind >= 17)
        begin
            repeat ($urandom_range(1, 5))
                line_bytes.push_back(8'($urandom_range(0, 255)));
            return;
        end
        line_bytes.push_back(efr_pkg::START_BYTE);
        if (kind >= 15 && cap != 16'hFFFF)
        begin
            len = ($urandom_range(0, 1) == 0) ? cap + 16'd1
                                              : 16'($urandom_range(cap + 1, 65535));
            add_field(len[15:8]);
            add_field(len[7:0]);
            count += line_bytes.size();
            return;
        end
        if (cap <= 40 && $urandom_range(0, 4) == 0)
            len = cap;
        else
            len = 16'($urandom_range(0, top));
        add_field(len[15:8]);
        add_field(len[7:0]);
        sum = 8'd0;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 11))
                0: value = efr_pkg::START_BYTE;
                1: value = efr_pkg::ESC_BYTE;
                default: value = 8'($urandom_range(0, 255));
            endcase
            add_field(value);
            sum = sum + value;
        end
        value = efr_pkg::SUM_BASE - sum;
        if (kind == 12)
            value = value ^ 8'($urandom_range(1, 255));
        add_field(value);
        // Chop the tail so that the next start byte lands inside this frame.
        if (kind == 13 || kind == 14)
        begin
            cut = $urandom_range(1, line_bytes.size() - 1);
            repeat (cut)
                void'(line_bytes.pop_back());
            if ($urandom_range(0, 2) == 0)
                line_bytes.push_back(efr_pkg::ESC_BYTE);
        end
        count += line_bytes.size();
    endtask

    task automatic send_byte(input logic [7:0] value);
        in_valid <= 1'b1;
        rx_byte  <= value;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        board.note_rx_byte(value);
    endtask

    task automatic send_line();
        while (line_bytes.size() != 0)
        begin
            if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 19))
                    @(posedge clk);
            end
            send_byte(line_bytes.pop_front());
        end
    endtask

    // Stops offering requests until every expected result is out and the pipe is empty.
    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);
    endtask

    initial
    begin
        int          sent;
        int          phase_no;
        bit          hold_done;
        bit          pause_done;
        logic [15:0] cap;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening_bytes[i])
            line_bytes.push_back(opening_bytes[i]);
        send_line();
        for (phase_no = 0; phase_no < 6; phase_no++)
        begin
            cap = efr_pkg::MAX_LEN_RST;
            if (phase_no > 0)
            begin
                settle();
                case (phase_no)
                    1: cap = 16'd0;
                    2: cap = 16'd1;
                    3: cap = 16'hFFFF;
                    4: cap = 16'($urandom_range(2, 60));
                    default: cap = efr_pkg::MAX_LEN_RST;
                endcase
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= cap;
                @(posedge clk);
                cfg_wr_en <= 1'b0;
                board.limit = cap;
            end
            gaps_on = (phase_no < 5);
            sent    = 0;
            while (sent < PHASE_BYTES)
            begin
                add_frame(cap, sent);
                send_line();
                if (phase_no == 3 && !hold_done && sent >= 60)
                begin
                    hold_request = 1'b1;
                    hold_done    = 1'b1;
                end
                if (phase_no == 2 && !pause_done && sent >= 60)
                begin
                    settle();
                    pause_done = 1'b1;
                end
            end
        end
        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        int stall_left;
        int run_left;
        stall_left = 0;
        run_left   = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ready === 1'b1 && out_valid !== 1'b0)
                board.check_frame_result(
                    efr_pkg::result_t'({data_byte, byte_index, frame_status, end_of_frame}));
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
                run_left     = 0;
            end
            if (stall_left == 0 && run_left == 0)
            begin
                if (gaps_on && $urandom_range(0, 2) == 0)
                    stall_left = $urandom_range(1, 19);
                else
                    run_left = $urandom_range(1, 40);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                run_left--;
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid === 1'b1 && in_ready === 1'b1) ||
                (out_valid === 1'b1 && out_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
